[rtl/core/tls_pkg.sv]
// ---------------------------------------------------------------------------
// tls_pkg: shared types and constants of the three-level task scheduler
// Table row layout, command codes, register indexes and widths used by the
// scheduler core, its draw sequencer and its remainder unit.
// ---------------------------------------------------------------------------
package tls_pkg;

	// Command codes carried in the input word's kind field.
	localparam logic [2:0] K_ALLOC = 3'd0;
	localparam logic [2:0] K_READY = 3'd1;
	localparam logic [2:0] K_YIELD = 3'd2;
	localparam logic [2:0] K_PICK  = 3'd3;
	localparam logic [2:0] K_LEVEL = 3'd4;
	localparam logic [2:0] K_TICK  = 3'd5;
	localparam logic [2:0] K_WSLOT = 3'd6;
	localparam logic [2:0] K_WALL  = 3'd7;

	// Configuration register indexes.
	localparam logic [1:0] REG_STARVE = 2'd0;
	localparam logic [1:0] REG_RLIMIT = 2'd1;
	localparam logic [1:0] REG_MAXTK  = 2'd2;

	// Width of a draw bound (a ticket total of up to 256 entries fits).
	localparam int HI_W = 16;
	// Width of an exact queue-three rank.
	localparam int RANK_W = 46;

	typedef struct packed {
		logic [31:0] run;
		logic [9:0]  rw;
		logic [9:0]  aw;
		logic [9:0]  pw;
		logic [7:0]  tickets;
		logic [31:0] entered;
		logic [1:0]  level;
	} tls_row_t;

	localparam int ROW_W = $bits(tls_row_t);

	// Contents of a row that has not been written since reset.
	function automatic tls_row_t row_rst();
		tls_row_t r;
		r.run     = 32'd0;
		r.rw      = 10'd1;
		r.aw      = 10'd1;
		r.pw      = 10'd1;
		r.tickets = 8'd0;
		r.entered = 32'd0;
		r.level   = 2'd2;
		return r;
	endfunction

endpackage

[rtl/core/tls_ram.sv]
// ---------------------------------------------------------------------------
// tls_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module tls_ram #(
	parameter int W = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/tls_rem.sv]
// ---------------------------------------------------------------------------
// tls_rem: bit-serial signed remainder
// Truncating remainder of a signed 32-bit dividend by a positive divisor,
// one quotient bit per cycle; the remainder takes the dividend's sign.
// ---------------------------------------------------------------------------
module tls_rem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [31:0]              x,
	input  logic [tls_pkg::HI_W-1:0] d,
	output logic                     done,
	output logic [31:0]              rem
);
	import tls_pkg::*;

	localparam int STEPS = 32;
	localparam int CW = $clog2(STEPS);

	logic            busy_q;
	logic            done_q;
	logic            neg_q;
	logic [31:0]     mag_q;
	logic [HI_W-1:0] r_q;
	logic [HI_W-1:0] d_q;
	logic [CW-1:0]   cnt_q;
	logic [HI_W:0]   tr;
	logic [HI_W-1:0] r_n;

	always_comb begin
		tr = {r_q, mag_q[31]};
		if (tr >= {1'b0, d_q}) begin
			r_n = HI_W'(tr - {1'b0, d_q});
		end else begin
			r_n = tr[HI_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= x[31];
			mag_q <= x[31] ? (32'd0 - x) : x;
			r_q   <= '0;
			d_q   <= d;
		end else if (busy_q) begin
			r_q   <= r_n;
			mag_q <= {mag_q[30:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = neg_q ? (32'd0 - 32'(r_q)) : 32'(r_q);

endmodule

[rtl/core/tls_draw.sv]
// ---------------------------------------------------------------------------
// tls_draw: tick-seeded pseudo random draw
// Sequences the shared remainder unit and one wrapping 32-bit multiplier
// through the draw formula for a bound hi and a tick count.
// ---------------------------------------------------------------------------
module tls_draw (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [tls_pkg::HI_W-1:0] hi,
	input  logic [31:0]              now,
	output logic                     busy,
	output logic                     done,
	output logic signed [31:0]       result
);
	import tls_pkg::*;

	localparam logic [2:0] DS_IDLE = 3'd0;
	localparam logic [2:0] DS_R1   = 3'd1;
	localparam logic [2:0] DS_M1   = 3'd2;
	localparam logic [2:0] DS_M2   = 3'd3;
	localparam logic [2:0] DS_R2   = 3'd4;
	localparam logic [2:0] DS_R3   = 3'd5;
	localparam logic [2:0] DS_M3   = 3'd6;
	localparam logic [2:0] DS_R4   = 3'd7;

	logic [2:0]      st_q;
	logic            pend_q;
	logic            done_q;
	logic [31:0]     res_q;
	logic [HI_W-1:0] hi_q;
	logic [31:0]     t_q;
	logic [31:0]     acc_q;
	logic [31:0]     c_q;
	logic            rem_start;
	logic [31:0]     rem_x;
	logic            rem_done;
	logic [31:0]     rem_val;
	logic [31:0]     mul_a;
	logic [31:0]     mul_b;
	logic [31:0]     mul_p;
	logic            in_rem;

	tls_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.x      (rem_x),
		.d      (hi_q),
		.done   (rem_done),
		.rem    (rem_val)
	);

	always_comb begin
		in_rem = (st_q == DS_R1) || (st_q == DS_R2) || (st_q == DS_R3) || (st_q == DS_R4);
		rem_start = in_rem && !pend_q;
		unique case (st_q)
			DS_R1:   rem_x = t_q + 32'd2;
			DS_R2:   rem_x = acc_q + 32'd1;
			DS_R3:   rem_x = t_q;
			default: rem_x = acc_q;
		endcase
		unique case (st_q)
			DS_M1: begin
				mul_a = acc_q;
				mul_b = t_q + 32'd1;
			end
			DS_M2: begin
				mul_a = acc_q;
				mul_b = 32'd132;
			end
			default: begin
				mul_a = c_q;
				mul_b = acc_q;
			end
		endcase
		mul_p = 32'(mul_a * mul_b);
	end

	// The formula's third factor, 1 + (2*hi) % hi, is always one because the
	// bound never exceeds 16 bits, so it is left out of the sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DS_IDLE;
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (rem_start) begin
				pend_q <= 1'b1;
			end
			unique case (st_q)
				DS_IDLE: begin
					if (start) begin
						if (hi <= HI_W'(1)) begin
							done_q <= 1'b1;
						end else begin
							st_q <= DS_R1;
						end
					end
				end
				DS_R1: begin
					if (pend_q && rem_done) begin
						pend_q <= 1'b0;
						st_q   <= DS_M1;
					end
				end
				DS_M1: st_q <= DS_M2;
				DS_M2: st_q <= DS_R2;
				DS_R2: begin
					if (pend_q && rem_done) begin
						pend_q <= 1'b0;
						st_q   <= DS_R3;
					end
				end
				DS_R3: begin
					if (pend_q && rem_done) begin
						pend_q <= 1'b0;
						st_q   <= DS_M3;
					end
				end
				DS_M3: st_q <= DS_R4;
				DS_R4: begin
					if (pend_q && rem_done) begin
						pend_q <= 1'b0;
						done_q <= 1'b1;
						st_q   <= DS_IDLE;
					end
				end
				default: st_q <= DS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == DS_IDLE && start) begin
			hi_q  <= hi;
			t_q   <= now;
			res_q <= 32'(hi);
		end
		if (pend_q && rem_done) begin
			unique case (st_q)
				DS_R1:   acc_q <= rem_val;
				DS_R2:   c_q   <= rem_val + 32'd1;
				DS_R3:   acc_q <= rem_val + 32'd1;
				default: res_q <= rem_val + 32'd1;
			endcase
		end
		if (st_q == DS_M1 || st_q == DS_M2 || st_q == DS_M3) begin
			acc_q <= mul_p;
		end
	end

	assign busy   = (st_q != DS_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

[rtl/core/three_level_task_scheduler_core.sv]
// ---------------------------------------------------------------------------
// three_level_task_scheduler_core: task table with aging, lottery and rank
// Keeps a table of task entries in a RAM and answers one command word with
// one result word; a pick walks the table with a small sequencer.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Contents
// s_*       in         s_tvalid/s_tready   one command word (kind in s_tuser)
// m_*       out        m_tvalid/m_tready   one result word per command
// cfg_*     in         cfg_we              register index and write data
//
// Allocate runs the draw, four bit-serial remainders in sequence. A pick
// runs the aging walk and stops there if queue one holds a runnable entry;
// else, if queue two holds runnable entries, the draw and the lottery walk
// follow, and the rank walk follows if neither found a winner. Each walk
// reads one table row per cycle through the single RAM read port.
// All-weights is one walk. Reset clears the runnable flags and the
// row-written flags at once; no clearing pass is needed. A result word
// that waits on m_tready holds the core in its final state only until the
// output register frees; the next command word is then taken.
// ---------------------------------------------------------------------------
module three_level_task_scheduler_core #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot[5:0], now[37:6], runnable[38], queue_level[40:39],
	// ticket_count[48:41], priority_weight[58:49], arrival_weight[68:59],
	// run_weight[78:69], zero[79]
	input  logic [79:0] s_tdata,
	// kind[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// found[0], chosen_slot[6:1], given_tickets[14:7], zero[15]
	output logic [15:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import tls_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int TW = $clog2(SLOTS * 255 + 1);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RMW_RD = 4'd1;
	localparam logic [3:0] S_RMW_WR = 4'd2;
	localparam logic [3:0] S_AGE    = 4'd3;
	localparam logic [3:0] S_DRAW   = 4'd4;
	localparam logic [3:0] S_LOT    = 4'd5;
	localparam logic [3:0] S_RANK   = 4'd6;
	localparam logic [3:0] S_WALL   = 4'd7;
	localparam logic [3:0] S_ADRAW  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	// Input word fields.
	logic [5:0]  in_slot;
	logic [31:0] in_now;
	logic        in_run;
	logic [1:0]  in_ql;
	logic [7:0]  in_tc;
	logic [9:0]  in_pw;
	logic [9:0]  in_aw;
	logic [9:0]  in_rw;
	logic        accept;

	assign in_slot = s_tdata[5:0];
	assign in_now  = s_tdata[37:6];
	assign in_run  = s_tdata[38];
	assign in_ql   = s_tdata[40:39];
	assign in_tc   = s_tdata[48:41];
	assign in_pw   = s_tdata[58:49];
	assign in_aw   = s_tdata[68:59];
	assign in_rw   = s_tdata[78:69];

	logic [3:0]    st_q;
	logic [2:0]    kind_q;
	logic [IW-1:0] sidx_q;
	logic [31:0]   now_q;
	logic [1:0]    ql_q;
	logic [7:0]    tc_q;
	logic [9:0]    pw_q;
	logic [9:0]    aw_q;
	logic [9:0]    rw_q;

	logic [31:0] starve_q;
	logic [31:0] rlimit_q;
	logic [7:0]  maxt_q;

	logic       out_v_q;
	logic       out_found_q;
	logic [5:0] out_slot_q;
	logic [7:0] out_tk_q;
	logic       res_found_q;
	logic [7:0] res_tk_q;

	logic ready_q [SLOTS];
	logic vld_q [SLOTS];

	// Table walk pipeline: read issue, row data, products, rank.
	logic          iss_q;
	logic [IW-1:0] rd_idx_q;
	logic          v_s1_q;
	logic [IW-1:0] idx_s1_q;
	logic          rvld_s1_q;
	logic          v_s2_q;
	logic          cand_s2;
	logic [IW-1:0] idx_s2;
	logic [41:0]   pe_s2;
	logic [41:0]   pr_s2;
	logic [9:0]    pw_s2;
	logic          v_s3_q;
	logic          cand_s3;
	logic [IW-1:0] idx_s3;
	logic [RANK_W-1:0] rk_s3;

	logic                best_found_q;
	logic [IW-1:0]       best_idx_q;
	logic signed [31:0]  best_wait_q;
	logic [TW-1:0]       total_q;
	logic                any2_q;
	logic signed [31:0]  ticket_q;
	logic [RANK_W-1:0]   best_rank_q;

	// RAM port signals.
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	tls_row_t      ram_wrow;
	logic [IW-1:0] ram_raddr;
	logic [ROW_W-1:0] ram_rdata;

	// Draw unit.
	logic               draw_start;
	logic [HI_W-1:0]    draw_hi;
	logic [31:0]        draw_now;
	logic               draw_busy;
	logic               draw_done;
	logic signed [31:0] draw_res;

	// Evaluation of the row in stage one.
	tls_row_t           row_s1;
	logic               rdy_s1;
	logic               aged;
	logic [1:0]         lvl_e;
	logic [31:0]        ent_e;
	logic signed [31:0] q1_w;
	logic               q1_upd;
	logic               q2_add;
	logic [TW-1:0]      total_n;
	logic               any2_n;
	logic               found_n;
	logic               lot_cand;
	logic signed [31:0] lot_tn;
	logic               lot_win;
	logic               rank_upd;
	logic [IW-1:0]      rmw_addr;
	tls_row_t           rmw_row;
	logic [7:0]         alloc_tk;
	logic               in_walk;
	logic               out_load;
	logic [RANK_W-1:0]  rank_init;
	logic [42:0]        rk_sum;

	assign s_tready = (st_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (st_q == S_DONE) && (!out_v_q || m_tready);
	assign in_walk  = (st_q == S_AGE) || (st_q == S_LOT) || (st_q == S_RANK) ||
		(st_q == S_WALL);

	tls_ram #(.W(ROW_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wrow),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tls_draw u_draw (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (draw_start),
		.hi     (draw_hi),
		.now    (draw_now),
		.busy   (draw_busy),
		.done   (draw_done),
		.result (draw_res)
	);

	always_comb begin
		row_s1 = rvld_s1_q ? tls_row_t'(ram_rdata) : row_rst();
		rdy_s1 = ready_q[idx_s1_q];

		// Aging: a runnable entry that has waited long enough moves to
		// queue one with a fresh entry time; it then has waited zero ticks.
		aged  = rdy_s1 && ((now_q - row_s1.entered) >= starve_q);
		lvl_e = aged ? 2'd1 : row_s1.level;
		ent_e = aged ? now_q : row_s1.entered;
		q1_w  = now_q - ent_e;

		q1_upd  = v_s1_q && (st_q == S_AGE) && rdy_s1 && (lvl_e == 2'd1) &&
			(q1_w > best_wait_q);
		q2_add  = v_s1_q && (st_q == S_AGE) && rdy_s1 && (lvl_e == 2'd2);
		total_n = q2_add ? (total_q + TW'(row_s1.tickets)) : total_q;
		any2_n  = any2_q || q2_add;
		found_n = best_found_q || q1_upd;

		lot_cand = v_s1_q && (st_q == S_LOT) && rdy_s1 && (row_s1.level == 2'd2);
		lot_tn   = ticket_q - $signed(32'(row_s1.tickets));
		lot_win  = lot_cand && (lot_tn <= 32'sd0);

		rank_upd = v_s3_q && cand_s3 && (rk_s3 < best_rank_q);
		rank_init = (RANK_W'(rlimit_q) << 3) + (RANK_W'(rlimit_q) << 1);

		rmw_addr = (kind_q == K_PICK) ? best_idx_q : sidx_q;

		rmw_row = row_s1;
		unique case (kind_q)
			K_YIELD: begin
				if (row_s1.run != 32'hFFFF_FFFF) begin
					rmw_row.run = row_s1.run + 32'd1;
				end
			end
			K_LEVEL: rmw_row.level = ql_q;
			K_TICK:  rmw_row.tickets = tc_q;
			K_WSLOT: begin
				rmw_row.pw = pw_q;
				rmw_row.aw = aw_q;
				rmw_row.rw = rw_q;
			end
			K_PICK:  rmw_row.entered = now_q;
			default: ;
		endcase

		// A negative draw on allocation gives no tickets.
		alloc_tk = draw_res[31] ? 8'd0 : draw_res[7:0];

		ram_we    = 1'b0;
		ram_waddr = idx_s1_q;
		ram_wrow  = row_s1;
		unique case (st_q)
			S_AGE: begin
				ram_we = v_s1_q && aged;
				ram_wrow.level   = 2'd1;
				ram_wrow.entered = now_q;
			end
			S_WALL: begin
				ram_we = v_s1_q;
				ram_wrow.pw = pw_q;
				ram_wrow.aw = aw_q;
				ram_wrow.rw = rw_q;
			end
			S_RMW_WR: begin
				ram_we    = 1'b1;
				ram_waddr = rmw_addr;
				ram_wrow  = rmw_row;
			end
			S_ADRAW: begin
				ram_we    = draw_done;
				ram_waddr = sidx_q;
				ram_wrow  = row_rst();
				ram_wrow.entered = now_q;
				ram_wrow.tickets = alloc_tk;
			end
			default: ;
		endcase

		ram_raddr = in_walk ? rd_idx_q : rmw_addr;

		// The draw starts on an allocate command, or at the end of the aging
		// walk when queue two holds runnable entries and queue one is empty.
		draw_start = 1'b0;
		if (accept && (s_tuser == K_ALLOC) && (32'(in_slot) < 32'(SLOTS))) begin
			draw_start = 1'b1;
		end
		if ((st_q == S_AGE) && v_s1_q && (idx_s1_q == LAST) && !found_n && any2_n) begin
			draw_start = 1'b1;
		end
		draw_hi  = (st_q == S_IDLE) ? HI_W'(maxt_q) : HI_W'(total_n);
		draw_now = (st_q == S_IDLE) ? in_now : now_q;
	end

	// Rank pipeline: products, then the exact rank scaled by ten.
	always_ff @(posedge clk) begin
		cand_s2 <= rdy_s1 && (row_s1.level == 2'd3);
		idx_s2  <= idx_s1_q;
		pe_s2   <= 42'(row_s1.entered * row_s1.aw);
		pr_s2   <= 42'(row_s1.run * row_s1.rw);
		pw_s2   <= row_s1.pw;
		cand_s3 <= cand_s2;
		idx_s3  <= idx_s2;
		rk_s3   <= (RANK_W'(rk_sum) << 3) + (RANK_W'(rk_sum) << 1) + RANK_W'(pr_s2);
	end

	assign rk_sum = 43'(pe_s2) + 43'(pw_s2);

	always_ff @(posedge clk) begin
		rvld_s1_q <= vld_q[ram_raddr];
		if (accept) begin
			kind_q <= s_tuser;
			sidx_q <= IW'(in_slot);
			now_q  <= in_now;
			ql_q   <= in_ql;
			tc_q   <= in_tc;
			pw_q   <= in_pw;
			aw_q   <= in_aw;
			rw_q   <= in_rw;
		end
		if (out_load) begin
			out_found_q <= res_found_q;
			out_slot_q  <= 6'(best_idx_q);
			out_tk_q    <= res_tk_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			starve_q     <= 32'd8000;
			rlimit_q     <= 32'd1000000;
			maxt_q       <= 8'd30;
			out_v_q      <= 1'b0;
			res_found_q  <= 1'b0;
			res_tk_q     <= 8'd0;
			iss_q        <= 1'b0;
			rd_idx_q     <= '0;
			v_s1_q       <= 1'b0;
			idx_s1_q     <= '0;
			v_s2_q       <= 1'b0;
			v_s3_q       <= 1'b0;
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			best_wait_q  <= '0;
			total_q      <= '0;
			any2_q       <= 1'b0;
			ticket_q     <= '0;
			best_rank_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				ready_q[i] <= 1'b0;
				vld_q[i]   <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STARVE: starve_q <= cfg_data;
					REG_RLIMIT: rlimit_q <= cfg_data;
					REG_MAXTK:  maxt_q   <= cfg_data[7:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end

			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end

			// Walk read issue and pipeline valids.
			v_s1_q   <= in_walk && iss_q;
			idx_s1_q <= rd_idx_q;
			v_s2_q   <= (st_q == S_RANK) && v_s1_q;
			v_s3_q   <= (st_q == S_RANK) && v_s2_q;
			if (in_walk && iss_q) begin
				if (rd_idx_q == LAST) begin
					iss_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end

			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						res_found_q  <= 1'b0;
						res_tk_q     <= 8'd0;
						best_idx_q   <= '0;
						best_found_q <= 1'b0;
						best_wait_q  <= '0;
						total_q      <= '0;
						any2_q       <= 1'b0;
						rd_idx_q     <= '0;
						if (s_tuser == K_PICK || s_tuser == K_WALL) begin
							iss_q <= 1'b1;
							st_q  <= (s_tuser == K_PICK) ? S_AGE : S_WALL;
						end else if (32'(in_slot) >= 32'(SLOTS)) begin
							st_q <= S_DONE;
						end else begin
							unique case (s_tuser)
								K_ALLOC: st_q <= S_ADRAW;
								K_READY: begin
									ready_q[IW'(in_slot)] <= in_run;
									st_q <= S_DONE;
								end
								default: st_q <= S_RMW_RD;
							endcase
						end
					end
				end
				S_RMW_RD: st_q <= S_RMW_WR;
				S_RMW_WR: begin
					if (kind_q == K_PICK) begin
						ready_q[best_idx_q] <= 1'b0;
						res_found_q <= 1'b1;
					end else if (kind_q == K_YIELD) begin
						ready_q[sidx_q] <= 1'b1;
					end
					st_q <= S_DONE;
				end
				S_ADRAW: begin
					if (draw_done) begin
						ready_q[sidx_q] <= 1'b0;
						res_tk_q <= alloc_tk;
						st_q <= S_DONE;
					end
				end
				S_AGE: begin
					total_q <= total_n;
					any2_q  <= any2_n;
					if (q1_upd) begin
						best_found_q <= 1'b1;
						best_idx_q   <= idx_s1_q;
						best_wait_q  <= q1_w;
					end
					if (v_s1_q && idx_s1_q == LAST) begin
						if (found_n) begin
							st_q <= S_RMW_RD;
						end else if (any2_n) begin
							st_q <= S_DRAW;
						end else begin
							best_rank_q <= rank_init;
							rd_idx_q    <= '0;
							iss_q       <= 1'b1;
							st_q        <= S_RANK;
						end
					end
				end
				S_DRAW: begin
					if (draw_done) begin
						ticket_q <= draw_res;
						rd_idx_q <= '0;
						iss_q    <= 1'b1;
						st_q     <= S_LOT;
					end
				end
				S_LOT: begin
					if (lot_cand) begin
						ticket_q <= lot_tn;
					end
					if (lot_win) begin
						best_found_q <= 1'b1;
						best_idx_q   <= idx_s1_q;
						iss_q        <= 1'b0;
						v_s1_q       <= 1'b0;
						st_q         <= S_RMW_RD;
					end else if (v_s1_q && idx_s1_q == LAST) begin
						best_rank_q <= rank_init;
						rd_idx_q    <= '0;
						iss_q       <= 1'b1;
						v_s1_q      <= 1'b0;
						st_q        <= S_RANK;
					end
				end
				S_RANK: begin
					if (rank_upd) begin
						best_rank_q  <= rk_s3;
						best_idx_q   <= idx_s3;
						best_found_q <= 1'b1;
					end
					if (v_s3_q && idx_s3 == LAST) begin
						v_s1_q <= 1'b0;
						v_s2_q <= 1'b0;
						v_s3_q <= 1'b0;
						st_q   <= (best_found_q || rank_upd) ? S_RMW_RD : S_DONE;
					end
				end
				S_WALL: begin
					if (v_s1_q && idx_s1_q == LAST) begin
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_tk_q, out_found_q ? out_slot_q : 6'd0, out_found_q};

`ifndef SYNTHESIS
	// After taking a command word the core is not ready in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("core ready right after taking a command");

	// The winner of a pick leaves the runnable set.
	a_winner_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_RMW_WR && kind_q == K_PICK) |=> !ready_q[$past(best_idx_q)])
		else $error("picked entry still runnable");

	// Walk stage data only exists during a walk.
	a_walk_contained: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q |-> (st_q == S_AGE || st_q == S_LOT || st_q == S_RANK || st_q == S_WALL))
		else $error("walk pipeline active outside a walk");

	// The draw unit is only started while it is idle.
	a_draw_idle: assert property (@(posedge clk) disable iff (!arst_n)
		draw_start |-> !draw_busy)
		else $error("draw started while busy");
`endif

endmodule

[bench/tls_checker.sv]
// ---------------------------------------------------------------------------
// tls_checker: result predictor and comparator for the task scheduler core
// Watches the command, result and register channels, keeps its own copy of
// the task table, predicts one result word per command and compares them.
// ---------------------------------------------------------------------------
module tls_checker #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fails,
	output int          pending
);
	import tls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Listed from the highest bit down, so found sits in bit zero.
	typedef struct packed {
		logic [7:0] tickets;
		logic [5:0] chosen;
		logic       found;
	} sched_result_t;

	sched_result_t result_q[$];

	logic [31:0] starve_lim, rank_lim;
	logic [7:0]  max_tk;
	logic        t_ready[SLOTS];
	logic [1:0]  t_level[SLOTS];
	logic [31:0] t_entered[SLOTS];
	logic [7:0]  t_tickets[SLOTS];
	logic [9:0]  t_pw[SLOTS], t_aw[SLOTS], t_rw[SLOTS];
	logic [31:0] t_run[SLOTS];

	assign pending = result_q.size();

	function automatic longint wrap32(longint v);
		return longint'($signed(v[31:0]));
	endfunction

	// Tick-seeded pseudo random draw in 32-bit wrapping signed arithmetic.
	function automatic longint seeded_draw(longint hi, logic [31:0] now);
		longint d, t, a, b, c, e, f, r;
		if (hi <= 1)
			return (hi > 0) ? hi : -hi;
		d = hi;
		t = wrap32(longint'(now));
		a = wrap32(t + 2) % d;
		b = wrap32(a * wrap32(t + 1));
		b = wrap32(b * 132);
		c = 1 + wrap32(1 + b) % d;
		e = 1 + t % hi;
		f = 1 + wrap32(2 * hi) % d;
		r = wrap32(wrap32(c * e) * f);
		return wrap32(r % d + 1);
	endfunction

	function automatic bit runnable_at(int i, logic [1:0] lvl);
		return t_ready[i] && t_level[i] == lvl;
	endfunction

	// Aging, then oldest-first, lottery and lowest rank, in that order.
	function automatic int choose_task(logic [31:0] now);
		int best;
		longint best_wait, total, ticket, w;
		longint unsigned best_rank, rk;
		best = -1;
		best_wait = 0;
		total = 0;
		for (int i = 0; i < SLOTS; i++)
			if (t_ready[i] && (now - t_entered[i]) >= starve_lim) begin
				t_level[i] = 2'd1;
				t_entered[i] = now;
			end
		for (int i = 0; i < SLOTS; i++) begin
			if (!runnable_at(i, 2'd1))
				continue;
			w = wrap32(longint'(now - t_entered[i]));
			if (w > best_wait) begin
				best_wait = w;
				best = i;
			end
		end
		if (best >= 0)
			return best;
		for (int i = 0; i < SLOTS; i++)
			if (runnable_at(i, 2'd2))
				total += t_tickets[i];
		ticket = seeded_draw(total, now);
		for (int i = 0; i < SLOTS; i++) begin
			if (!runnable_at(i, 2'd2))
				continue;
			ticket -= t_tickets[i];
			if (ticket <= 0)
				return i;
		end
		best_rank = longint'(rank_lim) * 10;
		for (int i = 0; i < SLOTS; i++) begin
			if (!runnable_at(i, 2'd3))
				continue;
			rk = 10 * longint'(t_pw[i]) + 10 * longint'(t_entered[i]) * longint'(t_aw[i])
				+ longint'(t_run[i]) * longint'(t_rw[i]);
			if (rk < best_rank) begin
				best_rank = rk;
				best = i;
			end
		end
		return best;
	endfunction

	function automatic sched_result_t schedule_command(logic [2:0] kind, logic [79:0] d);
		sched_result_t res;
		logic [5:0]  s;
		logic [31:0] now;
		logic [9:0]  pw, aw, rw;
		longint      tk;
		int          win;
		s   = d[5:0];
		now = d[37:6];
		pw  = d[58:49];
		aw  = d[68:59];
		rw  = d[78:69];
		res = '0;
		case (kind)
			K_PICK: begin
				win = choose_task(now);
				if (win >= 0) begin
					t_entered[win] = now;
					t_ready[win] = 1'b0;
					res.found = 1'b1;
					res.chosen = win[5:0];
				end
			end
			K_WALL: begin
				for (int i = 0; i < SLOTS; i++) begin
					t_pw[i] = pw;
					t_aw[i] = aw;
					t_rw[i] = rw;
				end
			end
			K_ALLOC: begin
				tk = seeded_draw(longint'(max_tk), now);
				if (tk < 0)
					tk = 0;
				t_ready[s] = 1'b0;
				t_level[s] = 2'd2;
				t_entered[s] = now;
				t_run[s] = '0;
				t_pw[s] = 10'd1;
				t_aw[s] = 10'd1;
				t_rw[s] = 10'd1;
				t_tickets[s] = tk[7:0];
				res.tickets = tk[7:0];
			end
			K_READY: t_ready[s] = d[38];
			K_YIELD: begin
				t_ready[s] = 1'b1;
				if (t_run[s] != 32'hFFFF_FFFF)
					t_run[s] = t_run[s] + 1;
			end
			K_LEVEL: t_level[s] = d[40:39];
			K_TICK:  t_tickets[s] = d[48:41];
			default: begin
				t_pw[s] = pw;
				t_aw[s] = aw;
				t_rw[s] = rw;
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_result_t want, got;
		if (!arst_n) begin
			starve_lim = 32'd8000;
			rank_lim = 32'd1000000;
			max_tk = 8'd30;
			for (int i = 0; i < SLOTS; i++) begin
				t_ready[i] = 1'b0;
				t_level[i] = 2'd2;
				t_entered[i] = '0;
				t_tickets[i] = '0;
				t_pw[i] = 10'd1;
				t_aw[i] = 10'd1;
				t_rw[i] = 10'd1;
				t_run[i] = '0;
			end
			result_q.delete();
			fails = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STARVE: starve_lim = cfg_data;
					REG_RLIMIT: rank_lim = cfg_data;
					REG_MAXTK:  max_tk = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				result_q.push_back(schedule_command(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[14:0];
				if (result_q.size() == 0) begin
					$error("unexpected result word %h", m_tdata);
					fails++;
				end else begin
					want = result_q.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0d actual %0d", want.found, got.found);
						fails++;
					end
					if (got.chosen !== want.chosen) begin
						$error("chosen_slot: expected %0d actual %0d", want.chosen, got.chosen);
						fails++;
					end
					if (got.tickets !== want.tickets) begin
						$error("given_tickets: expected %0d actual %0d",
							want.tickets, got.tickets);
						fails++;
					end
				end
			end
		end
	end

endmodule

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the three-level task scheduler core
// Drives directed and random command words in bursts against a stalling
// receiver, steps through several register settings and reports the result.
// ---------------------------------------------------------------------------
module tb_top;
	import tls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;
	// Generous ceiling for the whole run, gaps and stalls included.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_WORDS = 450;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [2:0]  s_tuser = K_ALLOC;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_STARVE;
	logic [31:0] cfg_data = '0;

	int fails, pending;
	int cycles = 0;
	// Sender burst bookkeeping: words left in the current burst.
	int burst_left = 0;
	// Running tick count; mostly creeps forward so that waits stay meaningful.
	logic [31:0] tick = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	three_level_task_scheduler_core #(.SLOTS(SLOTS)) dut (.*);

	tls_checker #(.SLOTS(SLOTS)) chk (.*);

	// The run is cut off if it takes far longer than any correct run could.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// The receiver alternates between stretches of steady readiness and
	// stretches where it stalls at random, each of random length.
	int rx_left = 0;
	bit rx_choppy = 1'b0;
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_left <= $urandom_range(5, 60);
			rx_choppy <= 1'($urandom_range(0, 1));
		end else begin
			rx_left <= rx_left - 1;
		end
		m_tready <= rx_choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
	end

	// Presents one command word and holds it until the core accepts it.
	// Ready is looked at mid-cycle, where nothing is changing.
	task automatic send_word(logic [2:0] kind, logic [5:0] slot, logic [31:0] now,
			logic rn, logic [1:0] lvl, logic [7:0] tk,
			logic [9:0] pw, logic [9:0] aw, logic [9:0] rw);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {1'b0, rw, aw, pw, tk, lvl, rn, now, slot};
		forever begin
			@(negedge clk);
			if (s_tready) begin
				@(posedge clk);
				break;
			end
		end
	endtask

	task automatic cmd(logic [2:0] kind, logic [5:0] slot, logic [31:0] now);
		send_word(kind, slot, now, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
			8'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
	endtask

	// Waits until every result word has come back; the edge first lets the
	// checker count a word taken at the edge just passed.
	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Register writes happen only once every result word has come back.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		s_tvalid <= 1'b0;
		burst_left = 0;
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly a handful of busy slots so that picks find competition.
	function automatic logic [5:0] busy_slot();
		return ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
	endfunction

	task automatic random_word();
		int roll;
		logic [5:0] s;
		roll = $urandom_range(0, 99);
		case ($urandom_range(0, 19))
			0: tick = $urandom;
			1: tick = tick + $urandom_range(5000, 20000);
			default: tick = tick + $urandom_range(0, 60);
		endcase
		s = busy_slot();
		if (roll < 10)
			cmd(K_ALLOC, s, tick);
		else if (roll < 30)
			send_word(K_READY, s, tick, ($urandom_range(0, 3) != 0), 2'd1, 8'($urandom),
				10'($urandom), 10'($urandom), 10'($urandom));
		else if (roll < 45)
			cmd(K_YIELD, s, tick);
		else if (roll < 70)
			cmd(K_PICK, s, tick);
		else if (roll < 80)
			send_word(K_LEVEL, s, tick, 1'b0, 2'($urandom_range(0, 12) / 4 + 0), 8'($urandom),
				10'($urandom), 10'($urandom), 10'($urandom));
		else if (roll < 88)
			cmd(K_TICK, s, tick);
		else if (roll < 95)
			send_word(K_WSLOT, s, tick, 1'b0, 2'd0, 8'd0, 10'($urandom_range(0, 1023)),
				10'($urandom_range(0, 40)), 10'($urandom_range(0, 1023)));
		else
			send_word(K_WALL, s, tick, 1'b0, 2'd0, 8'd0, 10'($urandom_range(0, 1023)),
				10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening with the reset register values. A pick on an empty
		// table finds nothing; allocations hit both ends of the tick range.
		cmd(K_PICK, 6'd0, 32'd0);
		send_word(K_ALLOC, 6'd0, 32'd0, 1'b0, 2'd0, 8'd0, 10'd0, 10'd0, 10'd0);
		send_word(K_ALLOC, 6'd63, 32'hFFFF_FFFF, 1'b1, 2'd3, 8'hFF,
			10'h3FF, 10'h3FF, 10'h3FF);
		cmd(K_ALLOC, 6'd1, 32'h8000_0000);
		cmd(K_ALLOC, 6'd2, 32'h7FFF_FFFF);
		send_word(K_READY, 6'd0, 32'd10, 1'b1, 2'd2, 8'd0, 10'd0, 10'd0, 10'd0);
		send_word(K_READY, 6'd1, 32'd10, 1'b1, 2'd2, 8'd0, 10'd0, 10'd0, 10'd0);
		// Lottery among queue-two entries, including one with zero tickets.
		send_word(K_TICK, 6'd1, 32'd10, 1'b0, 2'd0, 8'd0, 10'd0, 10'd0, 10'd0);
		send_word(K_TICK, 6'd0, 32'd10, 1'b0, 2'd0, 8'hFF, 10'd0, 10'd0, 10'd0);
		cmd(K_PICK, 6'd0, 32'd20);
		cmd(K_PICK, 6'd0, 32'd20);
		// Oldest-first in queue one, with the wait having to be positive.
		cmd(K_YIELD, 6'd2, 32'd30);
		send_word(K_LEVEL, 6'd2, 32'd30, 1'b0, 2'd1, 8'd0, 10'd0, 10'd0, 10'd0);
		cmd(K_PICK, 6'd0, 32'h7FFF_FFFF);
		// Queue three by weighted rank; a level of zero is never picked.
		send_word(K_WSLOT, 6'd63, 32'd40, 1'b0, 2'd0, 8'd0, 10'h3FF, 10'd0, 10'h3FF);
		send_word(K_LEVEL, 6'd63, 32'd40, 1'b0, 2'd3, 8'd0, 10'd0, 10'd0, 10'd0);
		cmd(K_YIELD, 6'd63, 32'd40);
		send_word(K_LEVEL, 6'd0, 32'd40, 1'b0, 2'd0, 8'd0, 10'd0, 10'd0, 10'd0);
		cmd(K_YIELD, 6'd0, 32'd40);
		cmd(K_PICK, 6'd0, 32'd50);
		send_word(K_WALL, 6'd0, 32'd60, 1'b0, 2'd0, 8'd0, 10'h3FF, 10'h3FF, 10'h3FF);
		send_word(K_READY, 6'd0, 32'd60, 1'b0, 2'd0, 8'd0, 10'd0, 10'd0, 10'd0);
		cmd(K_PICK, 6'd0, 32'd70);

		// Random phases, each under its own register setting, extremes first.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_STARVE, 32'd0);
					write_reg(REG_RLIMIT, 32'hFFFF_FFFF);
					write_reg(REG_MAXTK, 32'd1);
				end
				1: begin
					write_reg(REG_STARVE, 32'hFFFF_FFFF);
					write_reg(REG_RLIMIT, 32'd0);
					write_reg(REG_MAXTK, 32'd255);
				end
				2: begin
					write_reg(REG_STARVE, 32'd8000);
					write_reg(REG_RLIMIT, 32'd1000000);
					write_reg(REG_MAXTK, 32'd30);
				end
				default: begin
					write_reg(REG_STARVE, $urandom_range(0, 3) == 0 ? $urandom
						: $urandom_range(1, 20000));
					write_reg(REG_RLIMIT, $urandom);
					write_reg(REG_MAXTK, $urandom_range(1, 255) | ($urandom & 32'hFFFF_FF00));
				end
			endcase
			repeat (RANDOM_WORDS / 6)
				random_word();
		end

		s_tvalid <= 1'b0;
		drain();
		repeat (400) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
